[rtl/mbc_pkg.sv]
// Package for the mask boundary centroid block: widths, codes, state type and
// the command and status structs between controller and datapath.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mbc_pkg;

   // Default line and frame limits.
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Fixed field widths.
   localparam int CFG_DIM_W  = 13;
   localparam int ORIGIN_W   = 16;
   localparam int POS_W      = 17;
   localparam int RED_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Result payload: is_boundary, pos_x, pos_y, center_valid, center_x, center_y.
   localparam int RSP_FIELDS_W = 1 + POS_W + POS_W + 1 + POS_W + POS_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;
   localparam int REQ_DATA_W   = RED_W;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_ORIGIN_X     = 2'd2,
      CSR_ORIGIN_Y     = 2'd3
   } csr_index_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV_LOAD,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic eval;
      logic div_start;
      logic out_load;
   } mbc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_result;
      logic frame_end;
      logic div_busy;
      logic out_free;
   } mbc_status_type;

endpackage

[rtl/mbc_div.sv]
// Sequential signed divider for the centroid: one quotient bit per cycle.
// Depends on mbc_pkg for the result width.
`timescale 1ns / 1ps

module mbc_div
   import mbc_pkg::*;
#(
   parameter int DVD_W = 42,
   parameter int DVS_W = 25
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DVD_W-1:0] dividend,
   input  logic        [DVS_W-1:0] divisor,
   output logic                    busy,
   output logic        [POS_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [DVD_W-1:0]  magnitude;
   logic [DVS_W:0]    rem_shift;
   logic [DVS_W:0]    diff;
   logic [DVD_W-1:0]  quo_signed;

   // Magnitude of the dividend; the most negative value still fits unsigned.
   assign magnitude = dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;

   // One restoring step: shift in the next dividend bit and try the subtract.
   assign rem_shift = {rem_ff, quo_ff[DVD_W-1]};
   assign diff      = rem_shift - {1'b0, dvs_ff};

   // Step control.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // Quotient and remainder registers.
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[DVD_W-1];
         quo_ff <= magnitude;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[DVS_W]) begin
            rem_ff <= diff[DVS_W-1:0];
            quo_ff <= {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[DVS_W-1:0];
            quo_ff <= {quo_ff[DVD_W-2:0], 1'b0};
         end
      end
   end

   // Truncation toward zero: divide magnitudes, then restore the sign.
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = quo_signed[POS_W-1:0];
   assign busy       = busy_ff;

endmodule

[rtl/mbc_ctrl.sv]
// Controller state machine for the mask boundary centroid block.
// Depends on mbc_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps

module mbc_ctrl
   import mbc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  mbc_status_type status,
   output mbc_cmd_type    cmd
);

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            priority if (!status.has_result) state_in = ST_IDLE;
            else if (status.frame_end)       state_in = ST_DIV_LOAD;
            else                             state_in = ST_OUT;
         end
         ST_DIV_LOAD: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs.
   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
         end
         ST_DIV_WAIT: begin
         end
         ST_OUT: begin
            cmd.out_load = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/mbc_datapath.sv]
// Datapath of the mask boundary centroid block: configuration registers, line
// buffers, counters, accumulators, centroid dividers and the result register.
// Depends on mbc_pkg and mbc_div.
`timescale 1ns / 1ps

module mbc_datapath
   import mbc_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  mbc_cmd_type           cmd,
   output mbc_status_type        status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int X_W   = $clog2(MAX_WIDTH);
   localparam int WE_W  = X_W + 1;
   localparam int Y_W   = $clog2(MAX_HEIGHT + 1);
   localparam int WC_W  = (WE_W > CFG_DIM_W) ? WE_W : CFG_DIM_W;
   localparam int HC_W  = (Y_W > CFG_DIM_W) ? Y_W : CFG_DIM_W;
   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int SUM_W = CNT_W + POS_W;

   // Configuration registers.
   logic [CFG_DIM_W-1:0] cfg_width_ff;
   logic [CFG_DIM_W-1:0] cfg_height_ff;
   logic [ORIGIN_W-1:0]  cfg_origin_x_ff;
   logic [ORIGIN_W-1:0]  cfg_origin_y_ff;

   // Line buffers and their registered read data.
   logic                 row_cur[MAX_WIDTH];
   logic                 row_abv[MAX_WIDTH];
   logic                 mid_rd_ff;
   logic                 right_rd_ff;
   logic                 above_rd_ff;

   // Frame position, accumulators and the item being worked on.
   logic [X_W-1:0]       col_ff, col_in;
   logic [Y_W-1:0]       row_ff, row_in;
   logic signed [SUM_W-1:0] sum_x_ff, sum_y_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 left_ff;
   logic                 kind_ff;
   logic                 pix_ff;

   // Pending result.
   logic                 pend_edge_ff;
   logic [POS_W-1:0]     pend_px_ff;
   logic [POS_W-1:0]     pend_py_ff;
   logic                 pend_final_ff;
   logic                 cnt_nz_ff;

   // Result register.
   logic                 rsp_tvalid_ff;
   logic                 rsp_edge_ff;
   logic [POS_W-1:0]     rsp_px_ff;
   logic [POS_W-1:0]     rsp_py_ff;
   logic                 rsp_cv_ff;
   logic [POS_W-1:0]     rsp_cx_ff;
   logic [POS_W-1:0]     rsp_cy_ff;
   logic                 rsp_tlast_ff;

   // Combinational helpers.
   logic [WC_W-1:0]      wide_w;
   logic [HC_W-1:0]      wide_h;
   logic [WE_W-1:0]      eff_w;
   logic [Y_W-1:0]       eff_h;
   logic [WE_W-1:0]      col_p1;
   logic [X_W-1:0]       right_addr;
   logic                 col_last;
   logic                 done;
   logic                 row_nz;
   logic [Y_W-1:0]       y_rep;
   logic                 left_v, right_v, above_v, below_v;
   logic                 edge_det;
   logic [POS_W-1:0]     px, py;
   logic                 has_result;
   logic                 frame_end;
   logic                 pix_write;
   logic                 div_busy_x, div_busy_y;
   logic [POS_W-1:0]     quo_x, quo_y;

   // Configuration writes; the port is always ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff    <= CFG_DIM_W'(1);
         cfg_height_ff   <= CFG_DIM_W'(1);
         cfg_origin_x_ff <= '0;
         cfg_origin_y_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  cfg_width_ff    <= csr_data[CFG_DIM_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_height_ff   <= csr_data[CFG_DIM_W-1:0];
            CSR_ORIGIN_X:     cfg_origin_x_ff <= csr_data[ORIGIN_W-1:0];
            CSR_ORIGIN_Y:     cfg_origin_y_ff <= csr_data[ORIGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective frame size, saturated to one and the maximum.
   assign wide_w = WC_W'(cfg_width_ff);
   assign wide_h = HC_W'(cfg_height_ff);

   always_comb begin
      priority if (wide_w == '0)               eff_w = WE_W'(1);
      else if (wide_w > WC_W'(MAX_WIDTH))      eff_w = WE_W'(MAX_WIDTH);
      else                                     eff_w = wide_w[WE_W-1:0];
      priority if (wide_h == '0)               eff_h = Y_W'(1);
      else if (wide_h > HC_W'(MAX_HEIGHT))     eff_h = Y_W'(MAX_HEIGHT);
      else                                     eff_h = wide_h[Y_W-1:0];
   end

   // Frame position decode.
   assign col_p1     = {1'b0, col_ff} + WE_W'(1);
   assign col_last   = col_p1 >= eff_w;
   assign right_addr = (col_ff == X_W'(MAX_WIDTH - 1)) ? '0 : col_p1[X_W-1:0];
   assign done       = row_ff >= eff_h;
   assign row_nz     = row_ff != '0;
   assign y_rep      = row_ff - Y_W'(1);

   // Line buffer reads of the current and next column, registered each cycle.
   always_ff @(posedge clock) begin
      mid_rd_ff   <= row_cur[col_ff];
      right_rd_ff <= row_cur[right_addr];
      above_rd_ff <= row_abv[col_ff];
   end

   // Line buffer writes for a pixel inside the frame.
   assign pix_write = cmd.eval && !kind_ff && !done;

   always_ff @(posedge clock) begin
      if (pix_write) begin
         row_cur[col_ff] <= pix_ff;
         if (row_nz) begin
            row_abv[col_ff] <= mid_rd_ff;
         end
      end
   end

   // Neighbors of the reported pixel, clamped at the image edges.
   assign left_v   = (col_ff == '0) ? mid_rd_ff : left_ff;
   assign right_v  = col_last ? mid_rd_ff : right_rd_ff;
   assign above_v  = (row_ff == Y_W'(1)) ? mid_rd_ff : above_rd_ff;
   assign below_v  = kind_ff ? mid_rd_ff : pix_ff;
   assign edge_det = mid_rd_ff && !(left_v && right_v && above_v && below_v);

   // Reported coordinates with the origin added.
   assign px = POS_W'(col_ff)
      + {{(POS_W - ORIGIN_W){cfg_origin_x_ff[ORIGIN_W-1]}}, cfg_origin_x_ff};
   assign py = POS_W'(y_rep)
      + {{(POS_W - ORIGIN_W){cfg_origin_y_ff[ORIGIN_W-1]}}, cfg_origin_y_ff};

   // A pixel reports the row above once one row is in; a drain reports once
   // the frame is complete.
   assign has_result = kind_ff ? done : (!done && row_nz);
   assign frame_end  = kind_ff && done && col_last;

   // Column and row counters.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.eval) begin
         if (!kind_ff && !done) begin
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + Y_W'(1);
            end else begin
               col_in = col_p1[X_W-1:0];
            end
         end else if (kind_ff && done) begin
            if (col_last) begin
               col_in = '0;
               row_in = '0;
            end else begin
               col_in = col_p1[X_W-1:0];
            end
         end
      end
   end

   // Counters, accumulators and the left neighbor.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         cnt_ff   <= '0;
         left_ff  <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (cmd.div_start) begin
            sum_x_ff <= '0;
            sum_y_ff <= '0;
            cnt_ff   <= '0;
         end else if (cmd.eval && has_result && edge_det) begin
            sum_x_ff <= sum_x_ff + {{(SUM_W - POS_W){px[POS_W-1]}}, px};
            sum_y_ff <= sum_y_ff + {{(SUM_W - POS_W){py[POS_W-1]}}, py};
            cnt_ff   <= cnt_ff + CNT_W'(1);
         end
         if (cmd.eval && has_result) begin
            left_ff <= frame_end ? 1'b0 : mid_rd_ff;
         end
      end
   end

   // Accepted item and the pending result.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_tuser;
         pix_ff  <= |req_tdata;
      end
      if (cmd.eval) begin
         pend_edge_ff  <= edge_det;
         pend_px_ff    <= px;
         pend_py_ff    <= py;
         pend_final_ff <= frame_end;
      end
      if (cmd.div_start) begin
         cnt_nz_ff <= cnt_ff != '0;
      end
   end

   // Centroid dividers, started together at the end of the frame.
   mbc_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_x_ff),
      .divisor  (cnt_ff),
      .busy     (div_busy_x),
      .quotient (quo_x)
   );

   mbc_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_y_ff),
      .divisor  (cnt_ff),
      .busy     (div_busy_y),
      .quotient (quo_y)
   );

   // Result register; it frees once the downstream side takes the item.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_edge_ff  <= pend_edge_ff;
         rsp_px_ff    <= pend_px_ff;
         rsp_py_ff    <= pend_py_ff;
         rsp_cv_ff    <= pend_final_ff && cnt_nz_ff;
         rsp_cx_ff    <= (pend_final_ff && cnt_nz_ff) ? quo_x : '0;
         rsp_cy_ff    <= (pend_final_ff && cnt_nz_ff) ? quo_y : '0;
         rsp_tlast_ff <= pend_final_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_cy_ff, rsp_cx_ff, rsp_cv_ff,
                        rsp_py_ff, rsp_px_ff, rsp_edge_ff};

   // Status to the controller.
   assign status.has_result = has_result;
   assign status.frame_end  = frame_end;
   assign status.div_busy   = div_busy_x || div_busy_y;
   assign status.out_free   = !rsp_tvalid_ff || rsp_tready;

`ifndef SYNTH
   // Both dividers run once the frame-end division is started.
   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (div_busy_x && div_busy_y))
      else $error("centroid divider did not start");

   // Only the frame-end result carries a centroid.
   a_center_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tlast_ff) |-> !rsp_cv_ff)
      else $error("centroid flagged on a result that is not the last");

   // Accumulators are empty once the frame-end result has been loaded.
   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && pend_final_ff) |=> (cnt_ff == '0 && row_ff == '0))
      else $error("frame state not cleared after the last result");
`endif

endmodule

[rtl/mask_boundary_centroid_top.sv]
// Top level of the mask boundary centroid block: controller plus datapath.
// Depends on mbc_pkg, mbc_ctrl, mbc_datapath and mbc_div.
`timescale 1ns / 1ps

// Streams a mask image in raster order (req_tuser low, red value in req_tdata)
// and reports, one row late, whether each pixel is a land pixel with a water
// neighbor under 4-connectivity, with edges clamped. After the last row one
// drain item (req_tuser high) per column flushes the last row; the final
// drain also carries the centroid of all boundary pixels and rsp_tlast.
// Items are taken one at a time. An item that yields a result passes through
// accept, evaluation against the registered line-buffer reads, and the
// load of the result register, which holds a result while the next item is
// already accepted; the load waits as long as the previous result is still
// held back by the downstream side. An item that yields no result (a pixel of
// the first row, or an ignored pixel or drain) has only accept and evaluation.
// The frame-end drain additionally waits for the bit-serial centroid
// dividers, one quotient bit per cycle over the accumulator width (42 bits at
// the default size), between its evaluation and the load of its result. The
// line buffers need no clearing after reset.
module mask_boundary_centroid_top
   import mbc_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // red_value[7:0]
   input  logic                  req_tuser,  // kind
   // Result items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // is_boundary[0], pos_x[17:1],
                                             // pos_y[34:18], center_valid[35],
                                             // center_x[52:36], center_y[69:53]
   output logic                  rsp_tlast,  // last
   // Configuration writes.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   mbc_cmd_type    cmd;
   mbc_status_type status;

   // Register writes are taken in any cycle.
   assign csr_ready = 1'b1;

   mbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mbc_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
